// ===== rtl/core/vpid_pkg.sv =====
package vpid_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int GAIN_W  = 31;
    localparam int MOP_W   = 36;                  // multiplier operand, signed
    localparam int MAG_W   = 2 * MOP_W - FRAC_W;  // product magnitude after the fraction shift
    localparam int DVN_W   = DATA_W + FRAC_W;     // divider dividend
    localparam int DVD_W   = DATA_W;              // divider divisor
    localparam int ALPHA_W = FRAC_W + 1;
    localparam int ADDR_W  = 5;

    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_KP     = 3'd1;
    localparam logic [2:0] REG_KI     = 3'd2;
    localparam logic [2:0] REG_KD     = 3'd3;
    localparam logic [2:0] REG_TAU    = 3'd4;
    localparam logic [2:0] REG_MIN    = 3'd5;
    localparam logic [2:0] REG_MAX    = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_KITS,
        S_PROP,
        S_INTEG,
        S_DERIV,
        S_DDIV,
        S_FILT,
        S_SUM
    } state_t;

    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Saturate a wide signed sum to the data range.
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [MOP_W-1:0] x);
        logic signed [MOP_W-1:0] hi;
        logic signed [MOP_W-1:0] lo;
        hi = MOP_W'(SMAX);
        lo = MOP_W'(SMIN);
        if (x > hi)
            return SMAX;
        else if (x < lo)
            return SMIN;
        else
            return x[DATA_W-1:0];
    endfunction

    // Signed value from sign and magnitude, clamped to the data range.
    function automatic logic signed [DATA_W-1:0] sat_mag(input logic neg,
                                                         input logic [MAG_W-1:0] m);
        logic big;
        if (neg)
        begin
            big = (|m[MAG_W-1:DATA_W]) | (m[DATA_W-1] & (|m[DATA_W-2:0]));
            return big ? SMIN : -$signed(m[DATA_W-1:0]);
        end
        else
        begin
            big = |m[MAG_W-1:DATA_W-1];
            return big ? SMAX : $signed(m[DATA_W-1:0]);
        end
    endfunction

    function automatic logic signed [MOP_W-1:0] sx(input logic signed [DATA_W-1:0] x);
        return {{(MOP_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

endpackage

// ===== rtl/core/vpid_in_if.sv =====
interface vpid_in_if;
    import vpid_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  measured_value;
    logic                      sample_due;
    logic        [GAIN_W-1:0]  elapsed_time;

    modport source (output valid, measured_value, sample_due, elapsed_time, input ready);
    modport sink   (input valid, measured_value, sample_due, elapsed_time, output ready);
endinterface

// ===== rtl/core/vpid_out_if.sv =====
interface vpid_out_if;
    import vpid_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  drive_value;
    logic                      updated;

    modport source (output valid, drive_value, updated, input ready);
    modport sink   (input valid, drive_value, updated, output ready);
endinterface

// ===== rtl/core/vpid_mul.sv =====
// Serial shift-add multiplier, one multiplier bit per cycle; Q-shift and saturate on output.
module vpid_mul
    import vpid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MOP_W-1:0]  a,
    input  logic signed [MOP_W-1:0]  b,
    output logic                     done,
    output logic signed [DATA_W-1:0] res
);
    logic [MOP_W-1:0]   mcand_reg;
    logic [MOP_W-1:0]   mplier_reg;
    logic [2*MOP_W-1:0] acc_reg;
    logic [5:0]         cnt_reg;
    logic               busy_reg;
    logic               neg_reg;
    logic               done_reg;
    logic [MOP_W:0]     sum;

    assign sum = {1'b0, acc_reg[2*MOP_W-1:MOP_W]} + (mplier_reg[0] ? {1'b0, mcand_reg}
                                                                 : {(MOP_W+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(MOP_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= a[MOP_W-1] ? MOP_W'(-a) : MOP_W'(a);
            mplier_reg <= b[MOP_W-1] ? MOP_W'(-b) : MOP_W'(b);
            neg_reg    <= a[MOP_W-1] ^ b[MOP_W-1];
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= {sum, acc_reg[MOP_W-1:1]};
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done = done_reg;
    assign res  = sat_mag(neg_reg, acc_reg[2*MOP_W-1:FRAC_W]);
endmodule

// ===== rtl/core/vpid_div.sv =====
// Restoring divider, one quotient bit per cycle.
module vpid_div
    import vpid_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVN_W-1:0] dividend,
    input  logic [DVD_W-1:0] divisor,
    output logic             done,
    output logic [DVN_W-1:0] quo
);
    logic [DVN_W-1:0] quo_reg;
    logic [DVD_W-1:0] rem_reg;
    logic [DVD_W-1:0] dvs_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVD_W:0]   shifted;
    logic [DVD_W+1:0] trial;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DVN_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = ~trial[DVD_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DVN_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DVD_W-1:0] : shifted[DVD_W-1:0];
            quo_reg <= {quo_reg[DVN_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ===== rtl/core/velocity_pid_with_filtered_derivative_unit.sv =====
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   measured_value, sample_due, elapsed_time
// out_ch    out  valid/ready   drive_value, updated
// apb       in   psel/penable  7 config registers at 4*i, pready tied high
//
// Request with sample_due=0: result loaded into the output register at the accepting
// edge, valid the next cycle.
// Request with sample_due=1: five serial 36-bit multiplies and one 48-bit serial divide
// on the critical chain set the time from the accepting edge to out valid; the filter
// coefficient divide overlaps the multiplies.
// One request at a time; input ready is low while busy or while a result waits.
// rst_n asynchronous, active low; clears control, config and history to zero.
module velocity_pid_with_filtered_derivative_unit
    import vpid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    vpid_in_if.sink           in_ch,
    vpid_out_if.source        out_ch
);
    // configuration
    logic signed [DATA_W-1:0] target_reg, min_reg, max_reg;
    logic [GAIN_W-1:0]        kp_reg, ki_reg, kd_reg, tau_reg;
    logic                     wr_en;

    // history
    logic signed [DATA_W-1:0] ldrive_reg, lerr_reg, oerr_reg, lfd_reg;

    // per-request working values
    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] meas_reg, err_reg, kits_reg, p_reg, i_reg, fd_reg;
    logic [GAIN_W-1:0]        ts_reg;
    logic [ALPHA_W-1:0]       alpha_reg;
    logic                     dneg_reg;

    // output register
    logic                     ovalid_reg;
    logic signed [DATA_W-1:0] odrive_reg;
    logic                     oupd_reg;

    // shared serial units
    logic                     mul_start, mul_done, div_start, div_done;
    logic signed [MOP_W-1:0]  mul_a, mul_b;
    logic signed [DATA_W-1:0] mul_res;
    logic [DVN_W-1:0]         div_n, div_q;
    logic [DVD_W-1:0]         div_d;

    logic                     in_acc;
    logic signed [DATA_W-1:0] d_sat, err_next, fd_next, u_next, i_use;
    logic                     i_out;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            tau_reg    <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_TARGET: target_reg <= pwdata;
                REG_KP:     kp_reg     <= pwdata[GAIN_W-1:0];
                REG_KI:     ki_reg     <= pwdata[GAIN_W-1:0];
                REG_KD:     kd_reg     <= pwdata[GAIN_W-1:0];
                REG_TAU:    tau_reg    <= pwdata[GAIN_W-1:0];
                REG_MIN:    min_reg    <= pwdata;
                REG_MAX:    max_reg    <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_TARGET: prdata = target_reg;
            REG_KP:     prdata = {1'b0, kp_reg};
            REG_KI:     prdata = {1'b0, ki_reg};
            REG_KD:     prdata = {1'b0, kd_reg};
            REG_TAU:    prdata = {1'b0, tau_reg};
            REG_MIN:    prdata = min_reg;
            REG_MAX:    prdata = max_reg;
            default:    prdata = '0;
        endcase
    end

    vpid_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    vpid_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quo      (div_q)
    );

    assign in_ch.ready = (state_reg == S_IDLE) & ~ovalid_reg;
    assign in_acc      = in_ch.valid & in_ch.ready;

    assign err_next = sat_data(sx(target_reg) - sx(meas_reg));
    // derivative after the divide by ts, sign kept from the kd product
    assign d_sat    = sat_mag(dneg_reg, MAG_W'(div_q));
    assign fd_next  = sat_data(sx(lfd_reg) + sx(mul_res));
    // anti-windup: drop the integral step when outside the drive bounds
    assign i_out    = (i_reg < min_reg) | (i_reg > max_reg);
    assign i_use    = i_out ? '0 : i_reg;
    assign u_next   = sat_data(sx(ldrive_reg) + sx(p_reg) + sx(i_use) + sx(fd_reg));

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        // filter coefficient alpha = (ts << FRAC) / (tau + ts)
        div_n      = {1'b0, ts_reg, {FRAC_W{1'b0}}};
        div_d      = {1'b0, tau_reg} + {1'b0, ts_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_ch.sample_due)
                    state_next = S_ERR;
            end
            S_ERR:
            begin
                mul_start  = 1'b1;
                mul_a      = MOP_W'(ki_reg);
                mul_b      = MOP_W'(ts_reg);
                div_start  = 1'b1;
                state_next = S_KITS;
            end
            S_KITS:
            begin
                mul_a = MOP_W'(kp_reg);
                mul_b = sx(err_reg) - sx(lerr_reg);
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_PROP;
                end
            end
            S_PROP:
            begin
                mul_a = sx(kits_reg);
                mul_b = sx(err_reg);
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_INTEG;
                end
            end
            S_INTEG:
            begin
                mul_a = MOP_W'(kd_reg);
                mul_b = sx(err_reg) - (sx(lerr_reg) <<< 1) + sx(oerr_reg);
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_DERIV;
                end
            end
            S_DERIV:
            begin
                // |kd*dde| << FRAC / ts
                div_n = {(mul_res[DATA_W-1] ? DATA_W'(-mul_res) : mul_res), {FRAC_W{1'b0}}};
                div_d = {1'b0, ts_reg};
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DDIV;
                end
            end
            S_DDIV:
            begin
                mul_a = sx(d_sat) - sx(lfd_reg);
                mul_b = MOP_W'(alpha_reg);
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_FILT;
                end
            end
            S_FILT:
            begin
                if (mul_done)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            ldrive_reg <= '0;
            lerr_reg   <= '0;
            oerr_reg   <= '0;
            lfd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_ch.ready)
                ovalid_reg <= 1'b0;
            if (in_acc && !in_ch.sample_due)
                ovalid_reg <= 1'b1;
            if (state_reg == S_SUM)
            begin
                ovalid_reg <= 1'b1;
                ldrive_reg <= u_next;
                oerr_reg   <= lerr_reg;
                lerr_reg   <= err_reg;
                lfd_reg    <= fd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            meas_reg   <= in_ch.measured_value;
            ts_reg     <= (in_ch.elapsed_time == '0) ? GAIN_W'(1) : in_ch.elapsed_time;
            odrive_reg <= ldrive_reg;
            oupd_reg   <= 1'b0;
        end
        if (state_reg == S_ERR)
            err_reg <= err_next;
        if (mul_done && state_reg == S_KITS)
            kits_reg <= mul_res;
        if (mul_done && state_reg == S_PROP)
            p_reg <= mul_res;
        if (mul_done && state_reg == S_INTEG)
            i_reg <= mul_res;
        if (mul_done && state_reg == S_DERIV)
            dneg_reg <= mul_res[DATA_W-1];
        // alpha finishes while the multiplies run
        if (div_done && state_reg != S_DDIV)
            alpha_reg <= div_q[ALPHA_W-1:0];
        if (mul_done && state_reg == S_FILT)
            fd_reg <= fd_next;
        if (state_reg == S_SUM)
        begin
            odrive_reg <= u_next;
            oupd_reg   <= 1'b1;
        end
    end

    assign out_ch.valid       = ovalid_reg;
    assign out_ch.drive_value = odrive_reg;
    assign out_ch.updated     = oupd_reg;
endmodule

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vpid_pkg::*;

    // Run bounds. The limit allows for every request being sampled,
    // plus long stalls.
    localparam int  RAND_SEGMENTS  = 9;
    localparam int  SEG_REQUESTS   = 110;
    localparam int  HOLD_CYCLES    = 900;
    localparam int  DRAIN_CYCLES   = 400;
    localparam int  CYCLE_LIMIT    = 2000000;
    localparam int  MAX_REPORTS    = 10;
    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -64'sd2147483648;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    vpid_in_if  in_ch();
    vpid_out_if out_ch();

    velocity_pid_with_filtered_derivative_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic                     updated;
    } drive_result_t;

    // One row of the directed table. Rows with known_result carry a
    // hand-read expectation; the rest go through the controller model.
    typedef struct {
        logic signed [DATA_W-1:0] meas;
        logic                     due;
        logic [GAIN_W-1:0]        ts;
        logic                     known_result;
        logic signed [DATA_W-1:0] drive;
    } sample_row_t;

    // Controller model: configuration copy and loop history.
    longint cfg_target, cfg_kp, cfg_ki, cfg_kd, cfg_tau, cfg_min, cfg_max;
    longint prev_drive, prev_err, prev2_err, prev_fderiv;

    drive_result_t pending_drives[$];
    int  mismatches;
    int  src_idle_pct;
    int  snk_idle_pct;
    bit  hold_req;
    bit  sink_hold;
    longint cycles;

    // ---------------------------------------------------------------
    // Fixed-point helpers
    // ---------------------------------------------------------------
    function automatic longint clamp_q(longint x);
        if (x > Q_MAX)
            return Q_MAX;
        if (x < Q_MIN)
            return Q_MIN;
        return x;
    endfunction

    // Signed value from sign and magnitude, clamped to the 32-bit range
    function automatic longint from_magnitude(logic neg, logic [127:0] m);
        if (neg)
            return (m > 128'd2147483648) ? Q_MIN : -longint'(m[63:0]);
        return (m > 128'd2147483647) ? Q_MAX : longint'(m[63:0]);
    endfunction

    // (a*b) >> FRAC, truncated toward zero
    function automatic longint q_mul(longint a, longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        prod = (128'(ma) * 128'(mb)) >> FRAC_W;
        return from_magnitude((a < 0) != (b < 0), prod);
    endfunction

    // (n << FRAC) / d, truncated toward zero, d > 0
    function automatic longint q_div(longint n, longint d);
        logic [127:0] mn;
        mn = (n < 0) ? 128'(-n) : 128'(n);
        return from_magnitude(n < 0, (mn << FRAC_W) / 128'(d));
    endfunction

    // Advance the controller by one request and return the drive it emits
    function automatic drive_result_t step_controller(logic signed [DATA_W-1:0] meas,
                                                      logic due, logic [GAIN_W-1:0] ts_in);
        drive_result_t r;
        longint ts, err, p_inc, kits, i_inc, d_inc, alpha, fd, u;
        if (!due)
        begin
            r.drive   = DATA_W'(prev_drive);
            r.updated = 1'b0;
            return r;
        end
        ts    = (ts_in == 0) ? 1 : longint'(ts_in);   // zero time acts as one LSB
        err   = clamp_q(cfg_target - longint'(meas));
        p_inc = q_mul(cfg_kp, err - prev_err);
        kits  = q_mul(cfg_ki, ts);
        i_inc = q_mul(kits, err);
        if (i_inc < cfg_min || i_inc > cfg_max)        // anti-windup, reversed bounds drop all
            i_inc = 0;
        d_inc = q_mul(cfg_kd, err - 2 * prev_err + prev2_err);
        d_inc = q_div(d_inc, ts);
        alpha = (ts <<< FRAC_W) / (cfg_tau + ts);
        fd    = clamp_q(prev_fderiv + q_mul(d_inc - prev_fderiv, alpha));
        u     = clamp_q(prev_drive + p_inc + i_inc + fd);
        prev_drive  = u;
        prev2_err   = prev_err;
        prev_err    = err;
        prev_fderiv = fd;
        r.drive   = DATA_W'(u);
        r.updated = 1'b1;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Clock, reset, cycle limit
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result side: random stalls, a long hold-off on request, checking
    // ---------------------------------------------------------------
    always @(negedge clk)
        out_ch.ready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);

    // Long hold-off: the block finishes a request and then can't hand it
    // off, so its input stalls while the sender keeps offering.
    initial
    begin
        sink_hold = 1'b0;
        wait (hold_req);
        @(negedge clk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        sink_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_drives.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected drive result %0d updated %0b",
                             out_ch.drive_value, out_ch.updated);
            end
            else
            begin
                want = pending_drives.pop_front();
                if (out_ch.drive_value !== want.drive || out_ch.updated !== want.updated)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("drive mismatch: expected %0d/%0b got %0d/%0b",
                                 want.drive, want.updated,
                                 out_ch.drive_value, out_ch.updated);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Register writes and request driving
    // ---------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TARGET: cfg_target = longint'($signed(value));
            REG_KP:     cfg_kp     = longint'(value[GAIN_W-1:0]);
            REG_KI:     cfg_ki     = longint'(value[GAIN_W-1:0]);
            REG_KD:     cfg_kd     = longint'(value[GAIN_W-1:0]);
            REG_TAU:    cfg_tau    = longint'(value[GAIN_W-1:0]);
            REG_MIN:    cfg_min    = longint'($signed(value));
            REG_MAX:    cfg_max    = longint'($signed(value));
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] tgt, logic [31:0] kp, logic [31:0] ki,
                             logic [31:0] kd, logic [31:0] tau,
                             logic [31:0] lo, logic [31:0] hi);
        write_reg(REG_TARGET, tgt);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_TAU, tau);
        write_reg(REG_MIN, lo);
        write_reg(REG_MAX, hi);
    endtask

    // Stop offering, then the block is idle once every drive result is
    // back; the settle covers the output register.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_drives.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(logic signed [DATA_W-1:0] meas, logic due,
                                logic [GAIN_W-1:0] ts, logic known, drive_result_t known_res);
        int gap;
        drive_result_t res;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.measured_value <= meas;
        in_ch.sample_due     <= due;
        in_ch.elapsed_time   <= ts;
        do @(posedge clk); while (!in_ch.ready);
        res = step_controller(meas, due, ts);
        pending_drives.push_back(known ? known_res : res);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(32'h0002_0000);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    sample_row_t directed[$];

    initial
    begin
        drive_result_t r;
        sample_row_t row;
        logic signed [DATA_W-1:0] meas;
        logic [GAIN_W-1:0] ts;
        logic [31:0] lo, hi;
        int n_zero_rows;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        in_ch.valid          = 1'b0;
        in_ch.measured_value = '0;
        in_ch.sample_due     = 1'b0;
        in_ch.elapsed_time   = '0;
        out_ch.ready         = 1'b0;
        hold_req     = 1'b0;
        mismatches   = 0;
        src_idle_pct = 24;
        snk_idle_pct = 68;
        cfg_target = 0; cfg_kp = 0; cfg_ki = 0; cfg_kd = 0;
        cfg_tau = 0; cfg_min = 0; cfg_max = 0;
        prev_drive = 0; prev_err = 0; prev2_err = 0; prev_fderiv = 0;

        // With every gain at zero after reset, the drive stays at zero no
        // matter how extreme the sample is.
        directed.push_back('{32'sd0,          1'b1, 31'd1,          1'b1, 32'sd0});
        directed.push_back('{32'h7FFF_FFFF,   1'b1, 31'h7FFF_FFFF,  1'b1, 32'sd0});
        directed.push_back('{32'h8000_0000,   1'b1, 31'd1,          1'b1, 32'sd0});
        directed.push_back('{32'h5555_AAAA,   1'b0, 31'h2AAA_5555,  1'b1, 32'sd0});
        directed.push_back('{32'hAAAA_5555,   1'b1, 31'd0,          1'b1, 32'sd0});
        directed.push_back('{32'h0001_0000,   1'b0, 31'h0001_0000,  1'b1, 32'sd0});
        n_zero_rows = directed.size();
        // After the extreme configuration: saturation in both directions,
        // zero elapsed time, held output, and swings from one rail to the other.
        directed.push_back('{32'h8000_0000,   1'b1, 31'd1,          1'b0, 32'sd0});
        directed.push_back('{32'h7FFF_FFFF,   1'b1, 31'd1,          1'b0, 32'sd0});
        directed.push_back('{32'h8000_0000,   1'b1, 31'd0,          1'b0, 32'sd0});
        directed.push_back('{32'h0000_0000,   1'b0, 31'h7FFF_FFFF,  1'b0, 32'sd0});
        directed.push_back('{32'h7FFF_FFFF,   1'b1, 31'h7FFF_FFFF,  1'b0, 32'sd0});
        directed.push_back('{32'h0001_0000,   1'b1, 31'h0001_0000,  1'b0, 32'sd0});
        directed.push_back('{32'hFFFF_0000,   1'b1, 31'h0000_0100,  1'b0, 32'sd0});
        directed.push_back('{32'h0000_0001,   1'b1, 31'h0000_0001,  1'b0, 32'sd0});
        directed.push_back('{32'h8000_0000,   1'b0, 31'd1,          1'b0, 32'sd0});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        foreach (directed[k])
        begin
            if (k == n_zero_rows)
            begin
                wait_drained();
                write_all(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
            end
            row = directed[k];
            r.drive   = row.drive;
            r.updated = row.due;
            send_request(row.meas, row.due, row.ts, row.known_result, r);
        end

        // Random segments: three idling modes, each across a few settings.
        for (int seg = 0; seg < RAND_SEGMENTS; seg++)
        begin
            wait_drained();
            in_ch.valid <= 1'b0;
            case (seg / 3)
                0: begin src_idle_pct = 24; snk_idle_pct = 68; end
                1: begin src_idle_pct = 68; snk_idle_pct = 24; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            lo = $urandom;
            hi = $urandom;
            case (seg % 3)
                0: write_all($urandom, pick_gain(), pick_gain(), pick_gain(),
                             pick_gain(), 32'h8000_0000, 32'h7FFF_FFFF);
                1: write_all($urandom_range(32'h0010_0000), $urandom_range(32'h0002_0000),
                             $urandom_range(32'h0000_8000), $urandom_range(32'h0001_0000),
                             $urandom_range(32'h0004_0000),
                             -$urandom_range(32'h0100_0000), $urandom_range(32'h0100_0000));
                default: write_all($urandom, pick_gain(), pick_gain(), pick_gain(),
                                   pick_gain(), lo, hi);   // bounds often reversed
            endcase
            @(negedge clk);
            if (seg == 2)
                hold_req = 1'b1;

            meas = DATA_W'(cfg_target);
            for (int n = 0; n < SEG_REQUESTS; n++)
            begin
                if ($urandom_range(9) < 8)
                begin
                    // Tracking loop: measurement wanders near the setpoint
                    meas = meas + $signed(32'($urandom_range(32'h0004_0000))) - 32'sh0002_0000;
                    ts   = ($urandom_range(9) == 0) ? GAIN_W'($urandom)
                                                    : GAIN_W'($urandom_range(1, 32'h0002_0000));
                    send_request(meas, $urandom_range(4) != 0, ts, 1'b0, r);
                end
                else
                    send_request($urandom, 1'($urandom_range(1)), GAIN_W'($urandom), 1'b0, r);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_drives.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_drives.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== velocity_pid_with_filtered_derivative_unit.f =====
rtl/core/vpid_pkg.sv
rtl/core/vpid_in_if.sv
rtl/core/vpid_out_if.sv
rtl/core/vpid_mul.sv
rtl/core/vpid_div.sv
rtl/core/velocity_pid_with_filtered_derivative_unit.sv
dv/testbench.sv
